>>> design/ttiu_pkg.sv
// Package for the time table interpolator: sizes, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package ttiu_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int STAMP_W     = 63;
  localparam int COORD_W     = 32;
  localparam int LERP_STEPS  = COORD_W + 1;
  localparam int STEP_W      = $clog2(LERP_STEPS);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ANSWER  = 3'd0,
    ST_STORED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  // Where the result coordinates come from.
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_LO   = 2'd1,
    SRC_LERP = 2'd2
  } src_t;

  // Table read address selection.
  typedef enum logic [1:0] {
    RA_LO  = 2'd0,
    RA_HI  = 2'd1,
    RA_MID = 2'd2
  } rsel_t;

  typedef struct packed {
    logic    accept;
    logic    mem_wr;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    hi_zero;
    logic    lo_to_hi;
    logic    srch_upd;
    logic    lat_lo;
    logic    lat_hi;
    logic    lerp_start;
    logic    out_load;
    status_t out_status;
    src_t    out_src;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic cnt_zero;
    logic cnt_full;
    logic t_lt;
    logic t_gt;
    logic srch_more;
    logic span_pos;
    logic lerp_done;
  } stat_t;

endpackage

>>> design/time_table_interpolator_unit.sv
// Top level of the time table interpolator: stream ports, controller and datapath.
// Depends on ttiu_pkg, ttiu_ctrl and ttiu_dp.
//
// The block keeps a table of up to TABLE_DEPTH time-stamped points and answers
// piecewise-linear interpolation queries, one item at a time. An append or a
// clear goes straight to the result register. A query inside the table runs a
// bracketing binary search of at most ceil(log2(entry count)) probes through
// the single registered table read port, and each coordinate then goes through
// a 33-step serial multiplier and a 33-step restoring divider, both lanes side
// by side. A query time before the first entry or after the last entry needs
// no search; a query on a zero time span skips the interpolation. The next
// request is accepted while a finished result still waits in the output
// register. After reset the table reads as empty; there is no clearing pass.
module time_table_interpolator_unit import ttiu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // stamp_ns[62:0], point_x[94:63], point_y[126:95], zero
  input  logic [1:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // interp_x[31:0], interp_y[63:32]
  output logic [2:0]   out_tuser   // status
);

  cmd_t  cmd;
  stat_t stat;

  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;

  ttiu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ttiu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_stamp   (in_tdata[STAMP_W-1:0]),
    .in_x       (in_tdata[STAMP_W+COORD_W-1:STAMP_W]),
    .in_y       (in_tdata[STAMP_W+2*COORD_W-1:STAMP_W+COORD_W]),
    .out_status (out_tuser),
    .out_x      (res_x),
    .out_y      (res_y)
  );

  assign out_tdata = {res_y, res_x};

  // Any meaningful request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     (in_tuser == OP_APPEND || in_tuser == OP_QUERY || in_tuser == OP_CLEAR))
    |=> !in_tready)
    else $error("block accepted a request without going busy");

  // Only answered queries carry coordinates.
  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_ANSWER) |-> (out_tdata == '0))
    else $error("non-answer result carries coordinates");

  // No table write once the table is full.
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> !stat.cnt_full)
    else $error("table write while full");

  // A new result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule

>>> design/ttiu_lerp.sv
// One interpolation lane: a + (b - a) * num / den, quotient truncated.
// Serial shift-add multiplier followed by a restoring divider in one register.
// Depends on ttiu_pkg.
module ttiu_lerp import ttiu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  input  logic        [STAMP_W-1:0] num,
  input  logic        [STAMP_W-1:0] den,
  output logic                      done,
  output logic signed [COORD_W-1:0] res
);

  localparam int MAG_W  = COORD_W + 1;
  localparam int PROD_W = MAG_W + STAMP_W;

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} phase_t;

  phase_t              phase_r, phase_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [STAMP_W-1:0]  num_r, num_nxt;
  logic [STAMP_W-1:0]  den_r, den_nxt;
  logic [COORD_W-1:0]  a_r, a_nxt;
  logic                neg_r, neg_nxt;

  logic [MAG_W-1:0]    diff;
  logic [MAG_W-1:0]    mag;
  logic [STAMP_W-1:0]  part_hi;
  logic [MAG_W-1:0]    part_lo;
  logic [STAMP_W:0]    mul_sum;
  logic [STAMP_W:0]    div_r2;
  logic [STAMP_W:0]    div_diff;
  logic                div_ge;
  logic [COORD_W-1:0]  quo;
  logic                last_step;

  assign diff     = {b[COORD_W-1], b} - {a[COORD_W-1], a};
  assign mag      = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
  assign part_hi  = prod_r[PROD_W-1:MAG_W];
  assign part_lo  = prod_r[MAG_W-1:0];
  assign mul_sum  = {1'b0, part_hi} + (part_lo[0] ? {1'b0, num_r} : '0);
  assign div_r2   = {part_hi, part_lo[MAG_W-1]};
  assign div_ge   = div_r2 >= {1'b0, den_r};
  assign div_diff = div_r2 - {1'b0, den_r};
  assign last_step = step_r == STEP_W'(LERP_STEPS - 1);

  // After the divide the low bits hold the quotient; only its low word
  // matters, as the sum wraps to the coordinate width.
  assign quo  = prod_r[COORD_W-1:0];
  assign res  = a_r + (neg_r ? (~quo + COORD_W'(1)) : quo);
  assign done = phase_r == L_FIN;

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    case (phase_r)
      L_IDLE: begin
        if (start) begin
          phase_nxt = L_MUL;
          step_nxt  = '0;
          prod_nxt  = {{STAMP_W{1'b0}}, mag};
          num_nxt   = num;
          den_nxt   = den;
          a_nxt     = a;
          neg_nxt   = diff[MAG_W-1];
        end
      end
      L_MUL: begin
        prod_nxt = {mul_sum, part_lo[MAG_W-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (last_step) begin
          phase_nxt = L_DIV;
          step_nxt  = '0;
        end
      end
      L_DIV: begin
        // The upper part is already below den, since the quotient fits MAG_W bits.
        prod_nxt = {(div_ge ? div_diff[STAMP_W-1:0] : div_r2[STAMP_W-1:0]),
                    part_lo[MAG_W-2:0], div_ge};
        step_nxt = step_r + STEP_W'(1);
        if (last_step) begin
          phase_nxt = L_FIN;
        end
      end
      L_FIN: begin
        phase_nxt = L_IDLE;
      end
      default: begin
        phase_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      step_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    a_r    <= a_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

>>> design/ttiu_dp.sv
// Datapath of the time table interpolator: entry table, search bounds,
// bracketing points, two interpolation lanes and the result register.
// Depends on ttiu_pkg and ttiu_lerp.
module ttiu_dp import ttiu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [1:0]                in_op,
  input  logic        [STAMP_W-1:0] in_stamp,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output logic [2:0]                out_status,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y
);

  typedef struct packed {
    logic [STAMP_W-1:0] t;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_r;
  entry_t              lo_pt_r;
  entry_t              hi_pt_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]   lo_r;
  logic [ADDR_W-1:0]   hi_r;
  logic [ADDR_W-1:0]   mid_r;
  logic [2:0]          status_r;
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  y_r;

  logic [ADDR_W:0]     bound_sum;
  logic [ADDR_W-1:0]   mid;
  logic [ADDR_W-1:0]   rd_addr;
  logic [STAMP_W-1:0]  num;
  logic [STAMP_W-1:0]  den;
  logic                done_x;
  logic                done_y;
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  logic [CNT_W-1:0]    cnt_last;

  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = bound_sum[ADDR_W:1];
  assign cnt_last  = cnt_r - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RA_LO:   rd_addr = lo_r;
      RA_HI:   rd_addr = hi_r;
      RA_MID:  rd_addr = mid;
      default: rd_addr = lo_r;
    endcase
  end

  assign num = stamp_r - lo_pt_r.t;
  assign den = hi_pt_r.t - lo_pt_r.t;

  assign stat.in_op     = op_t'(in_op);
  assign stat.cnt_zero  = cnt_r == '0;
  assign stat.cnt_full  = cnt_r == CNT_W'(TABLE_DEPTH);
  assign stat.t_lt      = stamp_r < rd_r.t;
  assign stat.t_gt      = stamp_r > rd_r.t;
  assign stat.srch_more = {1'b0, hi_r} > ({1'b0, lo_r} + (ADDR_W + 1)'(1));
  assign stat.span_pos  = hi_pt_r.t > lo_pt_r.t;
  assign stat.lerp_done = done_x & done_y;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[cnt_r[ADDR_W-1:0]] <= '{t: in_stamp, x: in_x, y: in_y};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stamp_r <= in_stamp;
      lo_r    <= '0;
      hi_r    <= cnt_last[ADDR_W-1:0];
    end
    if (cmd.hi_zero) begin
      hi_r <= '0;
    end
    if (cmd.lo_to_hi) begin
      lo_r <= hi_r;
    end
    if (cmd.rd_en && cmd.rd_sel == RA_MID) begin
      mid_r <= mid;
    end
    // The probed time decides which half keeps the query time.
    if (cmd.srch_upd) begin
      if (stat.t_lt) begin
        hi_r <= mid_r;
      end else begin
        lo_r <= mid_r;
      end
    end
    if (cmd.lat_lo) begin
      lo_pt_r <= rd_r;
    end
    if (cmd.lat_hi) begin
      hi_pt_r <= rd_r;
    end
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      case (cmd.out_src)
        SRC_LO: begin
          x_r <= lo_pt_r.x;
          y_r <= lo_pt_r.y;
        end
        SRC_LERP: begin
          x_r <= res_x;
          y_r <= res_y;
        end
        default: begin
          x_r <= '0;
          y_r <= '0;
        end
      endcase
    end
  end

  ttiu_lerp u_lerp_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.lerp_start),
    .a     (lo_pt_r.x),
    .b     (hi_pt_r.x),
    .num   (num),
    .den   (den),
    .done  (done_x),
    .res   (res_x)
  );

  ttiu_lerp u_lerp_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.lerp_start),
    .a     (lo_pt_r.y),
    .b     (hi_pt_r.y),
    .num   (num),
    .den   (den),
    .done  (done_y),
    .res   (res_y)
  );

  assign out_status = status_r;
  assign out_x      = x_r;
  assign out_y      = y_r;

endmodule

>>> design/ttiu_ctrl.sv
// Controller of the time table interpolator: sequences loads, clears, the
// bracketing search and the interpolation, and owns the result valid flag.
// Depends on ttiu_pkg.
module ttiu_ctrl import ttiu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDN, S_CHKN, S_SRCH, S_CMP,
    S_FETCH_LO, S_FETCH_HI, S_FETCH_END, S_SPAN, S_LERP, S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  src_t    src_r, src_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    status_nxt    = status_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (stat.in_op)
            OP_APPEND: begin
              cmd.accept = 1'b1;
              src_nxt    = SRC_ZERO;
              state_nxt  = S_DONE;
              if (stat.cnt_full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.mem_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                status_nxt  = ST_STORED;
              end
            end
            OP_QUERY: begin
              cmd.accept = 1'b1;
              if (stat.cnt_zero) begin
                status_nxt = ST_EMPTY;
                src_nxt    = SRC_ZERO;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RD0;
              end
            end
            OP_CLEAR: begin
              cmd.accept  = 1'b1;
              cmd.cnt_clr = 1'b1;
              status_nxt  = ST_CLEARED;
              src_nxt     = SRC_ZERO;
              state_nxt   = S_DONE;
            end
            default: begin
              // An unused code is taken and gives no result.
            end
          endcase
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_LO;
        state_nxt  = S_RDN;
      end
      S_RDN: begin
        // First entry's time is here; the last entry is being read.
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_HI;
        if (stat.t_lt) begin
          cmd.hi_zero = 1'b1;
          state_nxt   = S_FETCH_LO;
        end else begin
          state_nxt = S_CHKN;
        end
      end
      S_CHKN: begin
        if (stat.t_gt) begin
          cmd.lo_to_hi = 1'b1;
          state_nxt    = S_FETCH_LO;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.srch_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_MID;
          state_nxt  = S_CMP;
        end else begin
          state_nxt = S_FETCH_LO;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_FETCH_LO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_LO;
        state_nxt  = S_FETCH_HI;
      end
      S_FETCH_HI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_HI;
        cmd.lat_lo = 1'b1;
        state_nxt  = S_FETCH_END;
      end
      S_FETCH_END: begin
        cmd.lat_hi = 1'b1;
        state_nxt  = S_SPAN;
      end
      S_SPAN: begin
        status_nxt = ST_ANSWER;
        if (stat.span_pos) begin
          cmd.lerp_start = 1'b1;
          src_nxt        = SRC_LERP;
          state_nxt      = S_LERP;
        end else begin
          src_nxt   = SRC_LO;
          state_nxt = S_DONE;
        end
      end
      S_LERP: begin
        if (stat.lerp_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_r;
          cmd.out_src    = src_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_ANSWER;
      src_r       <= SRC_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
